>>> rtl/opwl_pkg.sv
// opwl_pkg: shared widths, reset values, register codes and item types
// for the onset peak window locator; no dependencies
package opwl_pkg;

  // field widths
  localparam int SEQ_W     = 32;
  localparam int FI_W      = 32;
  localparam int E_W       = 16;
  localparam int PRE_W     = 6;
  localparam int SEARCH_W  = 7;
  localparam int PEAK_W    = 7;
  localparam int WIN_W     = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // one cell per frame the pre-roll search can reach, onset frame included
  localparam int SCAN_CELLS = 1 << PRE_W;

  // most negative energy
  localparam logic signed [E_W-1:0] E_MIN = {1'b1, {(E_W-1){1'b0}}};

  // register reset values
  localparam logic [PRE_W-1:0]    PRE_ROLL_RST = PRE_W'(15);
  localparam logic [SEARCH_W-1:0] SEARCH_RST   = SEARCH_W'(45);
  localparam logic [PEAK_W-1:0]   PEAK_POS_RST = PEAK_W'(15);
  localparam logic [WIN_W-1:0]    WINDOW_RST   = WIN_W'(61);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRE_ROLL = 2'd0,
    REG_SEARCH   = 2'd1,
    REG_PEAK_POS = 2'd2,
    REG_WINDOW   = 2'd3
  } cfg_reg_t;

  // input item
  typedef struct packed {
    logic [SEQ_W-1:0]        block_seq;
    logic signed [E_W-1:0]   energy;
    logic                    onset;
    logic                    listening;
  } in_item_t;

  // result item
  typedef struct packed {
    logic             frame_valid;
    logic [FI_W-1:0]  frame_index;
    logic [SEQ_W-1:0] gap_blocks;
    logic             window_ready;
    logic [FI_W-1:0]  window_start;
    logic [FI_W-1:0]  window_number;
  } out_item_t;

  // running best carried from cell to cell during the pre-roll search
  typedef struct packed {
    logic                  valid;
    logic signed [E_W-1:0] e;
    logic [PRE_W-1:0]      d;
  } scan_tok_t;

  // controls from the sequencer to the cell row
  typedef struct packed {
    logic             shift;
    logic             launch;
    logic [PRE_W-1:0] lim;
  } chain_ctl_t;

endpackage

>>> rtl/opwl_chan_if.sv
// opwl_chan_if: valid/ready channel carrying one request of a given payload type
// payload types come from opwl_pkg at the instantiation site
interface opwl_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/opwl_cell.sv
// opwl_cell: one history cell, holds the energy of one recent frame and
// folds it into the running best as the search token passes; uses opwl_pkg
module opwl_cell #(
  parameter int INDEX = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shift,
  input  logic [opwl_pkg::PRE_W-1:0]     lim,
  input  logic signed [opwl_pkg::E_W-1:0] energy_in,
  output logic signed [opwl_pkg::E_W-1:0] energy_out,
  input  opwl_pkg::scan_tok_t            tok_in,
  output opwl_pkg::scan_tok_t            tok_out
);
  import opwl_pkg::*;

  localparam logic [PRE_W-1:0] IDX = PRE_W'(INDEX);

  logic signed [E_W-1:0] energy_q;
  logic                  tok_valid;
  logic signed [E_W-1:0] tok_e;
  logic [PRE_W-1:0]      tok_d;
  logic                  take;

  // history shifts by one frame each time a frame is made
  always_ff @(posedge clk) begin
    if (shift) begin
      energy_q <= energy_in;
    end
  end

  // going back in time, ties go to the older frame
  assign take = (IDX <= lim) && (energy_q >= tok_in.e);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_e <= energy_q;
      tok_d <= IDX;
    end else begin
      tok_e <= tok_in.e;
      tok_d <= tok_in.d;
    end
  end

  assign energy_out = energy_q;
  assign tok_out    = '{valid: tok_valid, e: tok_e, d: tok_d};

endmodule

>>> rtl/opwl_chain.sv
// opwl_chain: row of history cells, newest frame in cell zero; the search
// token enters at cell zero and leaves the last cell; uses opwl_pkg, opwl_cell
module opwl_chain (
  input  logic                            clk,
  input  logic                            rst,
  input  opwl_pkg::chain_ctl_t            ctl,
  input  logic signed [opwl_pkg::E_W-1:0] energy,
  output opwl_pkg::scan_tok_t             tok_end
);
  import opwl_pkg::*;

  logic signed [E_W-1:0] e_q [SCAN_CELLS];
  scan_tok_t             tok [SCAN_CELLS];
  scan_tok_t             tok_launch;

  // fresh token, the first cell always takes its own frame
  assign tok_launch = '{valid: ctl.launch, e: E_MIN, d: '0};

  for (genvar j = 0; j < SCAN_CELLS; j++) begin : g_cell
    if (j == 0) begin : g_head
      opwl_cell #(.INDEX(j)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (ctl.shift),
        .lim        (ctl.lim),
        .energy_in  (energy),
        .energy_out (e_q[j]),
        .tok_in     (tok_launch),
        .tok_out    (tok[j])
      );
    end else begin : g_body
      opwl_cell #(.INDEX(j)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (ctl.shift),
        .lim        (ctl.lim),
        .energy_in  (e_q[j-1]),
        .energy_out (e_q[j]),
        .tok_in     (tok[j-1]),
        .tok_out    (tok[j])
      );
    end
  end

  assign tok_end = tok[SCAN_CELLS-1];

endmodule

>>> rtl/onset_peak_window_locator.sv
// onset_peak_window_locator: pairs audio blocks into frames, finds the
// onset peak and reports the peak-aligned window start
// uses opwl_pkg, opwl_chan_if, opwl_chain
//
// Usage:
//   items   - one request per audio block: block_seq, energy (Q8.8), onset,
//             listening; accepted when valid and ready are both high
//   results - exactly one request back per item, in order
//   cfg_we/cfg_index/cfg_data - register writes, taken on any edge with
//             cfg_we high; write only while the block is idle
// Sequencing: a block that only primes pairing goes straight to the push
// state; a frame without a new search passes the track and both window
// states; a frame that starts a search waits in the scan state while the
// token walks back over the pre-roll frames through the 64-cell history
// row, one cell a cycle. One item is worked on at a time; the next one is
// taken once the result sits in the output register.
// Reset (rst, synchronous): registers return to 15/45/15/61, no frame is
// paired, frame and window counts restart at zero, no search is pending.
// A stalled receiver holds the result register; one further item may be
// worked on meanwhile and waits before its result is pushed.
module onset_peak_window_locator (
  input  logic                            clk,
  input  logic                            rst,
  opwl_chan_if.sink                       items,
  opwl_chan_if.source                     results,
  input  logic                            cfg_we,
  input  logic [opwl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [opwl_pkg::CFG_W-1:0]      cfg_data
);
  import opwl_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_TRACK = 6'b000100,
    ST_WIN_A = 6'b001000,
    ST_WIN_B = 6'b010000,
    ST_PUSH  = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [PRE_W-1:0]    back_span;
  logic [SEARCH_W-1:0] search_len;
  logic [PEAK_W-1:0]   peak_pos;
  logic [WIN_W-1:0]    win_len;

  // block state
  logic [SEQ_W-1:0]      next_seq;
  logic                  prev_present;
  logic [FI_W-1:0]       frame_ctr;
  logic                  pending;
  logic [FI_W-1:0]       search_last;
  logic [FI_W-1:0]       best_fi;
  logic signed [E_W-1:0] best_e;
  logic [FI_W-1:0]       windows_sent;

  // item in flight
  logic [FI_W-1:0]       item_fi;
  logic signed [E_W-1:0] item_e;
  logic [PRE_W-1:0]      lim;
  logic                  launch_q;
  logic [FI_W-1:0]       wstart;
  logic                  past_end;
  out_item_t             res;

  // output register
  logic      out_valid;
  out_item_t out_q;

  logic                  in_fire;
  logic [SEQ_W-1:0]      gap;
  logic                  makes_frame;
  logic [WIN_W-1:0]      win_m1;
  logic [FI_W-1:0]       wlast;
  logic                  win_done;
  chain_ctl_t            ctl;
  scan_tok_t             tok_end;

  assign items.ready = (state == ST_IDLE);
  assign in_fire     = items.valid && items.ready;

  // expected sequence gives zero difference
  assign gap         = items.data.block_seq - next_seq;
  assign makes_frame = prev_present && (gap == '0);

  // window end check
  assign win_m1   = (win_len == '0) ? '0 : win_len - WIN_W'(1);
  assign wlast    = wstart + FI_W'(win_m1);
  assign win_done = past_end && (item_fi >= wlast);

  // history row control
  assign ctl = '{shift: in_fire && makes_frame, launch: launch_q, lim: lim};

  opwl_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .energy  (items.data.energy),
    .tok_end (tok_end)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      back_span  <= PRE_ROLL_RST;
      search_len <= SEARCH_RST;
      peak_pos   <= PEAK_POS_RST;
      win_len    <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRE_ROLL: back_span  <= cfg_data[PRE_W-1:0];
        REG_SEARCH:   search_len <= cfg_data[SEARCH_W-1:0];
        REG_PEAK_POS: peak_pos   <= cfg_data[PEAK_W-1:0];
        REG_WINDOW:   win_len    <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      next_seq     <= '0;
      prev_present <= 1'b0;
      frame_ctr    <= '0;
      pending      <= 1'b0;
      search_last  <= '0;
      best_fi      <= '0;
      best_e       <= E_MIN;
      windows_sent <= '0;
      launch_q     <= 1'b0;
    end else begin
      launch_q <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            next_seq         <= items.data.block_seq + SEQ_W'(1);
            prev_present     <= 1'b1;
            item_fi          <= frame_ctr;
            item_e           <= items.data.energy;
            lim              <= (frame_ctr < FI_W'(back_span)) ? frame_ctr[PRE_W-1:0]
                                                                : back_span;
            res.frame_valid   <= makes_frame;
            res.frame_index   <= makes_frame ? frame_ctr : '0;
            res.gap_blocks    <= gap;
            res.window_ready  <= 1'b0;
            res.window_start  <= '0;
            res.window_number <= '0;
            if (!makes_frame) begin
              state <= ST_PUSH;
            end else if (items.data.onset && items.data.listening && !pending) begin
              launch_q <= 1'b1;
              state    <= ST_SCAN;
            end else begin
              state <= ST_TRACK;
            end
          end
        end
        // wait for the token to leave the last cell
        ST_SCAN: begin
          search_last <= item_fi + FI_W'(search_len);
          if (tok_end.valid) begin
            best_e  <= tok_end.e;
            best_fi <= item_fi - FI_W'(tok_end.d);
            pending <= 1'b1;
            state   <= ST_WIN_A;
          end
        end
        // follow the peak after the onset
        ST_TRACK: begin
          if (pending && (item_fi <= search_last) && (item_e > best_e)) begin
            best_e  <= item_e;
            best_fi <= item_fi;
          end
          state <= ST_WIN_A;
        end
        // window start, clamped at frame zero
        ST_WIN_A: begin
          wstart    <= (best_fi >= FI_W'(peak_pos)) ? best_fi - FI_W'(peak_pos) : '0;
          past_end  <= pending && (item_fi >= search_last);
          frame_ctr <= item_fi + FI_W'(1);
          state     <= ST_WIN_B;
        end
        ST_WIN_B: begin
          if (win_done) begin
            res.window_ready  <= 1'b1;
            res.window_start  <= wstart;
            res.window_number <= windows_sent;
            windows_sent      <= windows_sent + FI_W'(1);
            pending           <= 1'b0;
          end
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (!out_valid || results.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_PUSH && (!out_valid || results.ready)) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUSH && (!out_valid || results.ready)) begin
      out_q <= res;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_q;

`ifndef SYNTH
  // the search result only comes back while the sequencer waits for it
  a_scan_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_end.valid |-> state == ST_SCAN)
    else $error("search token left the row outside the scan wait");

  // a window is only reported on a frame
  a_win_on_frame: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.data.window_ready) |-> results.data.frame_valid)
    else $error("window reported without a frame");

  // a pending search ends only through a reported window
  a_pending_end: assert property (@(posedge clk) disable iff (rst)
    ($fell(pending) && !$past(rst)) |-> $past(state == ST_WIN_B && win_done))
    else $error("search dropped without a window");
`endif

endmodule
